[hdl/crmn_pkg.sv]
// Package with shared types and constants of the change-rate min-max normalizer.
package crmn_pkg;
    localparam int NFEAT = 5;
    localparam logic signed [31:0] Q824_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q824_MIN = 32'sh8000_0000;
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RATE  = 7'b0000010,
        ST_DIVW  = 7'b0000100,
        ST_RDREQ = 7'b0001000,
        ST_RDWT  = 7'b0010000,
        ST_NORM  = 7'b0100000,
        ST_NDIVW = 7'b1000000
    } state_t;
endpackage

[hdl/crmn_ram.sv]
// Generic single-port-write, registered-read RAM.
module crmn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5120
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/crmn_div.sv]
// Radix-2 restoring divider for unsigned 64-bit numerator by 64-bit divisor.
module crmn_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic [63:0] quo
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;
endmodule

[hdl/change_rate_minmax_normalizer.sv]
// Top level of the change-rate min-max normalizer.
// A push runs its features in turn through one serial 64-step divider.
// A read does, per feature, a store read and then a division in the same divider.
// Items are handled one at a time; stall is high while one is in work or a result waits.
// The result register holds one item; reset clears counters and previous row and sets min/max to their extremes.
// The rate store has no reset; only written entries are ever read.
module change_rate_minmax_normalizer #(
    parameter int MAX_ROWS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [31:0] fx_rate,
    input  logic signed [31:0] rate_gap,
    input  logic signed [31:0] dollar_index,
    input  logic signed [31:0] stock_index,
    input  logic signed [31:0] oil_price,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               row_valid,
    output logic [9:0]         row_number,
    output logic [15:0]        norm_rate,
    output logic [15:0]        norm_gap,
    output logic [15:0]        norm_dollar,
    output logic [15:0]        norm_stock,
    output logic [15:0]        norm_oil
);
    localparam int DEPTH = MAX_ROWS * crmn_pkg::NFEAT;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_ROWS + 1);

    crmn_pkg::state_t state_reg, state_next;
    logic signed [31:0] prev_reg [crmn_pkg::NFEAT];
    logic signed [31:0] x_reg [crmn_pkg::NFEAT];
    logic signed [31:0] min_reg [crmn_pkg::NFEAT];
    logic signed [31:0] max_reg [crmn_pkg::NFEAT];
    logic               have_prev_reg;
    logic [CW-1:0]      rows_reg;
    logic [CW-1:0]      rptr_reg;
    logic [2:0]         f_reg;
    logic [AW-1:0]      addr_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [15:0]        nv_reg [crmn_pkg::NFEAT];
    logic               ovalid_reg;
    logic               rvalid_reg;
    logic [9:0]         rnum_reg;

    logic        we;
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic        div_start;
    logic        div_busy;
    logic [63:0] dnum, dden, dquo;
    logic signed [32:0] diff;
    logic signed [63:0] sq;
    logic [CW-1:0] next_row;
    logic signed [32:0] nden, nnum;
    logic signed [31:0] rate;

    crmn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(addr_reg), .wdata(wdata),
        .raddr(addr_reg), .rdata(rdata)
    );

    crmn_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
        .busy(div_busy), .quo(dquo)
    );

    assign next_row = rptr_reg + CW'(1);
    assign diff = 33'(x_reg[f_reg]) - 33'(prev_reg[f_reg]);
    assign nden = 33'(max_reg[f_reg]) - 33'(min_reg[f_reg]);
    assign nnum = 33'($signed(rdata)) - 33'(min_reg[f_reg]);

    always_comb
    begin
        dnum = '0;
        dden = '0;
        div_start = 1'b0;
        if (state_reg == crmn_pkg::ST_RATE)
        begin
            div_start = 1'b1;
            dnum = {7'd0, (diff[32] ? -diff : diff), 24'd0};
            dden = prev_reg[f_reg][31] ? 64'(-65'(prev_reg[f_reg]))
                                       : 64'(prev_reg[f_reg]);
        end
        else if (state_reg == crmn_pkg::ST_NORM)
        begin
            div_start = 1'b1;
            dnum = {15'd0, nnum, 16'd0};
            dden = 64'(nden);
        end
    end

    always_comb
    begin
        sq = neg_reg ? -$signed(dquo) : $signed(dquo);
        if (dquo[63:32] != '0)
        begin
            rate = neg_reg ? crmn_pkg::Q824_MIN : crmn_pkg::Q824_MAX;
        end
        else if (sq > 64'sh7FFF_FFFF)
        begin
            rate = crmn_pkg::Q824_MAX;
        end
        else if (sq < -64'sh8000_0000)
        begin
            rate = crmn_pkg::Q824_MIN;
        end
        else
        begin
            rate = sq[31:0];
        end
        if (zero_reg)
        begin
            rate = '0;
        end
    end

    assign wdata = rate;
    assign we = (state_reg == crmn_pkg::ST_DIVW) && !div_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crmn_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (command == crmn_pkg::CMD_PUSH)
                    begin
                        if (rows_reg < CW'(MAX_ROWS) && have_prev_reg)
                        begin
                            state_next = crmn_pkg::ST_RATE;
                        end
                    end
                    else if (next_row < rows_reg)
                    begin
                        state_next = crmn_pkg::ST_RDREQ;
                    end
                end
            end
            crmn_pkg::ST_RATE:  state_next = crmn_pkg::ST_DIVW;
            crmn_pkg::ST_DIVW:
            begin
                if (!div_busy)
                begin
                    state_next = (f_reg == 3'(crmn_pkg::NFEAT - 1)) ? crmn_pkg::ST_IDLE
                                                                    : crmn_pkg::ST_RATE;
                end
            end
            crmn_pkg::ST_RDREQ: state_next = crmn_pkg::ST_RDWT;
            crmn_pkg::ST_RDWT:  state_next = crmn_pkg::ST_NORM;
            crmn_pkg::ST_NORM:  state_next = crmn_pkg::ST_NDIVW;
            crmn_pkg::ST_NDIVW:
            begin
                if (!div_busy)
                begin
                    state_next = (f_reg == 3'(crmn_pkg::NFEAT - 1)) ? crmn_pkg::ST_IDLE
                                                                    : crmn_pkg::ST_RDREQ;
                end
            end
            default: state_next = crmn_pkg::ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != crmn_pkg::ST_IDLE) || ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crmn_pkg::ST_IDLE;
            have_prev_reg <= 1'b0;
            rows_reg      <= '0;
            rptr_reg      <= '0;
            ovalid_reg    <= 1'b0;
            for (int i = 0; i < crmn_pkg::NFEAT; i++)
            begin
                prev_reg[i] <= '0;
                min_reg[i]  <= crmn_pkg::Q824_MAX;
                max_reg[i]  <= crmn_pkg::Q824_MIN;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == crmn_pkg::ST_IDLE && in_valid && !in_stall)
            begin
                if (command == crmn_pkg::CMD_PUSH)
                begin
                    if (rows_reg < CW'(MAX_ROWS))
                    begin
                        have_prev_reg <= 1'b1;
                        rows_reg <= rows_reg + CW'(1);
                        if (!have_prev_reg)
                        begin
                            prev_reg[0] <= fx_rate;
                            prev_reg[1] <= rate_gap;
                            prev_reg[2] <= dollar_index;
                            prev_reg[3] <= stock_index;
                            prev_reg[4] <= oil_price;
                        end
                    end
                end
                else if (!(next_row < rows_reg))
                begin
                    ovalid_reg <= 1'b1;
                end
            end
            if (we)
            begin
                if (rate < min_reg[f_reg]) min_reg[f_reg] <= rate;
                if (rate > max_reg[f_reg]) max_reg[f_reg] <= rate;
                prev_reg[f_reg] <= x_reg[f_reg];
            end
            if (state_reg == crmn_pkg::ST_NDIVW && !div_busy &&
                f_reg == 3'(crmn_pkg::NFEAT - 1))
            begin
                ovalid_reg <= 1'b1;
                rptr_reg <= next_row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            crmn_pkg::ST_IDLE:
            begin
                f_reg <= '0;
                x_reg[0] <= fx_rate;
                x_reg[1] <= rate_gap;
                x_reg[2] <= dollar_index;
                x_reg[3] <= stock_index;
                x_reg[4] <= oil_price;
                if (command == crmn_pkg::CMD_PUSH)
                begin
                    addr_reg <= AW'(rows_reg * crmn_pkg::NFEAT);
                end
                else
                begin
                    addr_reg <= AW'(next_row * crmn_pkg::NFEAT);
                    if (in_valid && !in_stall)
                    begin
                        rvalid_reg <= (next_row < rows_reg);
                        rnum_reg <= (next_row < rows_reg) ? 10'(next_row) : 10'd0;
                        for (int i = 0; i < crmn_pkg::NFEAT; i++)
                        begin
                            nv_reg[i] <= '0;
                        end
                    end
                end
            end
            crmn_pkg::ST_RATE:
            begin
                neg_reg  <= diff[32] ^ prev_reg[f_reg][31];
                zero_reg <= (prev_reg[f_reg] == '0);
            end
            crmn_pkg::ST_DIVW:
            begin
                if (!div_busy)
                begin
                    f_reg <= f_reg + 3'd1;
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            crmn_pkg::ST_NORM:
            begin
                zero_reg <= (nden <= 0) || (nnum <= 0);
            end
            crmn_pkg::ST_NDIVW:
            begin
                if (!div_busy)
                begin
                    nv_reg[f_reg] <= zero_reg ? 16'd0
                                   : (dquo > 64'd65535) ? 16'hFFFF : dquo[15:0];
                    f_reg <= f_reg + 3'd1;
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = ovalid_reg;
    assign row_valid   = rvalid_reg;
    assign row_number  = rnum_reg;
    assign norm_rate   = nv_reg[0];
    assign norm_gap    = nv_reg[1];
    assign norm_dollar = nv_reg[2];
    assign norm_stock  = nv_reg[3];
    assign norm_oil    = nv_reg[4];
endmodule

[hdl/crmn_checker.sv]
// Port-level assertions for the change-rate min-max normalizer, with bind.
module crmn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        command,
    input logic        out_valid,
    input logic        out_stall,
    input logic        row_valid,
    input logic [9:0]  row_number,
    input logic [15:0] norm_rate
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_number))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted while result pending");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !row_valid |-> row_number == 10'd0 && norm_rate == 16'd0)
        else $error("empty result not zero");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !command |=> !out_valid)
        else $error("push produced a result");
endmodule

bind change_rate_minmax_normalizer crmn_checker u_crmn_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .out_valid(out_valid), .out_stall(out_stall),
    .row_valid(row_valid), .row_number(row_number), .norm_rate(norm_rate)
);
